// ----- sv/tksel_pkg.sv -----
// Shared types, constants and helpers for the top-k score selection block.
package tksel_pkg;

	localparam int SCORE_W = 16;
	localparam int INDEX_W = 10;
	localparam int KEEP_W  = 4;

	localparam int MAX_KEEP_DEF    = 8;
	localparam int MAX_CLASSES_DEF = 1024;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCORE_THRESHOLD = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_QUANTIZED_MODE  = 2'd2;

	localparam logic [KEEP_W-1:0]  KEEP_COUNT_RST      = 4'd5;
	localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RST = 16'd66;

	typedef struct packed {
		logic [SCORE_W-1:0] raw_score;
		logic               final_score;
	} item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] confidence;
		logic [INDEX_W-1:0] class_index;
		logic               found;
		logic               run_end;
	} result_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [INDEX_W-1:0] index;
	} pair_t;

	// per-step control from the input stage to the kept list
	typedef struct packed {
		logic step;
		logic admit;
		logic last;
	} list_ctl_t;

	// a ranks above b: higher score, or equal score and higher index
	function automatic logic ranks_above(pair_t a, pair_t b);
		if (a.score != b.score) begin
			return a.score > b.score;
		end
		return a.index > b.index;
	endfunction

endpackage

// ----- sv/tksel_list.sv -----
// Kept list of best (score, index) pairs with compare-and-shift sorted insertion.
module tksel_list import tksel_pkg::*; #(
	parameter int MAX_KEEP = MAX_KEEP_DEF,
	localparam int CW = $clog2(MAX_KEEP + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	input  list_ctl_t ctl,
	input  pair_t     new_pair,
	input  logic [CW-1:0] cap,
	output pair_t     snap [MAX_KEEP],
	output logic [CW-1:0] snap_count
);

	pair_t         list_q [MAX_KEEP];
	logic [CW-1:0] kept_q;

	logic [CW-1:0] n;
	logic [MAX_KEEP-1:0] ge;
	logic [MAX_KEEP-1:0] at_cap;
	pair_t         shifted [MAX_KEEP];
	logic          full;
	logic          insert;

	assign n = (kept_q < cap) ? kept_q : cap;

	// ge[j]: entry j is live and stays ahead of the new pair
	for (genvar j = 0; j < MAX_KEEP; j++) begin : g_slot
		assign ge[j]     = (j < int'(n)) && !ranks_above(new_pair, list_q[j]);
		assign at_cap[j] = (j + 1 == int'(cap));
		if (j == 0) begin : g_head
			assign shifted[j] = ge[j] ? list_q[j] : new_pair;
		end else begin : g_tail
			assign shifted[j] = ge[j] ? list_q[j] : (ge[j-1] ? new_pair : list_q[j-1]);
		end
	end

	assign full   = (n == cap) && |(ge & at_cap);
	assign insert = ctl.admit && !full;

	// a dropped score leaves the count alone; the final score reports at most cap
	always_comb begin
		if (insert) begin
			snap       = shifted;
			snap_count = (n < cap) ? n + CW'(1) : cap;
		end else begin
			snap       = list_q;
			snap_count = (ctl.admit || ctl.last) ? n : kept_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
		end else if (ctl.step) begin
			kept_q <= ctl.last ? '0 : snap_count;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && !ctl.last) begin
			list_q <= snap;
		end
	end

endmodule

// ----- sv/tksel_emit.sv -----
// Result buffer: takes a snapshot of the kept list and shifts it out best first.
module tksel_emit import tksel_pkg::*; #(
	parameter int MAX_KEEP = MAX_KEEP_DEF,
	localparam int CW = $clog2(MAX_KEEP + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  pair_t         snap [MAX_KEEP],
	input  logic [CW-1:0] snap_count,
	output logic          idle,
	output logic          result_valid,
	input  logic          result_ready,
	output result_t       result
);

	pair_t         buf_q [MAX_KEEP];
	logic [CW-1:0] rem_q;
	logic          found_q;
	logic          take;

	assign idle         = (rem_q == '0);
	assign result_valid = !idle;
	assign take         = result_valid && result_ready;

	assign result.confidence  = buf_q[0].score;
	assign result.class_index = buf_q[0].index;
	assign result.found       = found_q;
	assign result.run_end     = (rem_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			found_q <= 1'b0;
		end else if (load) begin
			// an empty run still reports one not-found result
			rem_q   <= (snap_count == '0) ? CW'(1) : snap_count;
			found_q <= (snap_count != '0);
		end else if (take) begin
			rem_q <= rem_q - CW'(1);
		end
	end

	for (genvar j = 0; j < MAX_KEEP; j++) begin : g_buf
		always_ff @(posedge clk) begin
			if (load) begin
				buf_q[j] <= (j == 0 && snap_count == '0) ? pair_t'('0) : snap[j];
			end else if (take && j < MAX_KEEP - 1) begin
				buf_q[j] <= buf_q[(j + 1) % MAX_KEEP];
			end
		end
	end

endmodule

// ----- sv/top_k_select_threshold_unit.sv -----
// Top level of the streaming top-k score selection block.
// Scores arrive one per transaction, each tagged with a running class position,
// and the block accepts one score per clock unless a final score is held. A
// registered input stage widens a quantized byte to Q0.16 (byte*257), drops
// scores below the threshold and inserts the rest into a sorted list of the
// best keep_count pairs in a single compare-and-shift step. On the transaction
// flagged final the list is copied to a result buffer, cleared, and the buffer
// shifts out one result per cycle while result_ready is high, best first: n
// results for n kept pairs, or one not-found result. Scores of the next vector
// keep streaming during that output; only its final score waits in the input
// stage until the previous run's results have all been taken.
module top_k_select_threshold_unit import tksel_pkg::*; #(
	parameter int MAX_KEEP    = MAX_KEEP_DEF,
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result
);

	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int PW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

	logic [KEEP_W-1:0]    keep_count_q;
	logic [SCORE_W-1:0]   score_threshold_q;
	logic                 quantized_mode_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_write;

	item_t         item_s1;
	logic          valid_s1;
	logic [PW-1:0] position_q;

	logic [SCORE_W-1:0] score;
	logic [CW-1:0]      cap;
	logic               emit_idle;
	logic               advance;
	list_ctl_t          ctl;
	pair_t              new_pair;
	pair_t              snap [MAX_KEEP];
	logic [CW-1:0]      snap_count;

	// configuration port
	assign pready    = 1'b1;
	assign reg_idx   = paddr[APB_ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q      <= KEEP_COUNT_RST;
			score_threshold_q <= SCORE_THRESHOLD_RST;
			quantized_mode_q  <= 1'b0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_KEEP_COUNT:      keep_count_q      <= pwdata[KEEP_W-1:0];
				REG_SCORE_THRESHOLD: score_threshold_q <= pwdata[SCORE_W-1:0];
				REG_QUANTIZED_MODE:  quantized_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KEEP_COUNT:      prdata = APB_DATA_W'(keep_count_q);
			REG_SCORE_THRESHOLD: prdata = APB_DATA_W'(score_threshold_q);
			REG_QUANTIZED_MODE:  prdata = APB_DATA_W'(quantized_mode_q);
			default:             prdata = '0;
		endcase
	end

	// keep count of zero acts as one, above the list depth as the depth
	always_comb begin
		if (keep_count_q == '0) begin
			cap = CW'(1);
		end else if (int'(keep_count_q) > MAX_KEEP) begin
			cap = CW'(MAX_KEEP);
		end else begin
			cap = CW'(keep_count_q);
		end
	end

	// input stage
	assign advance    = valid_s1 && (!item_s1.final_score || emit_idle);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (advance) begin
			if (item_s1.final_score || position_q == PW'(MAX_CLASSES - 1)) begin
				position_q <= '0;
			end else begin
				position_q <= position_q + PW'(1);
			end
		end
	end

	// byte*257 is byte/255 in Q0.16
	assign score = quantized_mode_q ? {item_s1.raw_score[7:0], item_s1.raw_score[7:0]}
	                                : item_s1.raw_score;

	assign new_pair.score = score;
	assign new_pair.index = INDEX_W'(position_q);

	assign ctl.step  = advance;
	assign ctl.admit = advance && (score >= score_threshold_q);
	assign ctl.last  = item_s1.final_score;

	tksel_list #(
		.MAX_KEEP(MAX_KEEP)
	) u_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.new_pair  (new_pair),
		.cap       (cap),
		.snap      (snap),
		.snap_count(snap_count)
	);

	tksel_emit #(
		.MAX_KEEP(MAX_KEEP)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && item_s1.final_score),
		.snap        (snap),
		.snap_count  (snap_count),
		.idle        (emit_idle),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	a_not_found_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.run_end && result.confidence == '0)
		else $error("not-found result is not a lone empty result");

	a_descending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.run_end |=>
		result_valid && result.found && $past(result.confidence) >= result.confidence)
		else $error("results out of order or run cut short");

	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.final_score && result_valid |-> !advance)
		else $error("new run loaded over pending results");

endmodule

// ----- bench/top_k_select_threshold_unit_test.sv -----
// Testbench for top_k_select_threshold_unit: directed table, then random vectors vs a predictor.
`timescale 1ns / 1ps

module top_k_select_threshold_unit_test;
	import tksel_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int END_CYCLES   = 12;
	localparam int RANDOM_ITEMS = 130;

	// an address past the register map; writes there must change nothing
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_BURSTY} ready_mode_e;
	typedef enum logic [1:0] {STYLE_ANY, STYLE_EDGE, STYLE_TIES} score_style_e;
	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

	typedef struct {
		row_kind_e             kind;
		logic [REG_IDX_W-1:0]  reg_idx;
		logic [APB_DATA_W-1:0] wdata;
		logic [SCORE_W-1:0]    raw;
		int                    repeats;
		logic                  last;
		bit                    pinned;
		result_t               pin;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;

	// predictor state
	logic [SCORE_W-1:0] kept_scores [MAX_KEEP_DEF];
	logic [INDEX_W-1:0] kept_indices [MAX_KEEP_DEF];
	int                 kept_total;
	int                 class_pos;
	logic [KEEP_W-1:0]  cfg_keep;
	logic [SCORE_W-1:0] cfg_threshold;
	logic               cfg_quantized;

	result_t ranked_results [$];
	int      fail_count = 0;
	int      quiet_cycles = 0;
	bit      steady = 1'b0;
	int      burst_left = 0;
	int      random_items = 0;

	ready_mode_e ready_mode = READY_ALWAYS;
	int          mode_left = 0;
	int          stall_left = 0;

	top_k_select_threshold_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #5 clk = ~clk;

	task automatic log_failure(input string msg);
		if (fail_count < 10) begin
			$display("mismatch: %s", msg);
		end
		fail_count++;
	endtask

	task automatic queue_result(input result_t r);
		ranked_results = {ranked_results, r};
	endtask

	task automatic clear_ranking();
		for (int k = 0; k < MAX_KEEP_DEF; k++) begin
			kept_scores[k] = '0;
			kept_indices[k] = '0;
		end
		kept_total = 0;
		class_pos = 0;
	endtask

	// compare-and-shift insertion, then emission on the final score
	task automatic rank_score(input item_t it);
		int cap;
		int n;
		int slot;
		int k;
		logic [SCORE_W-1:0] score;
		logic [INDEX_W-1:0] idx;
		result_t r;
		cap = (cfg_keep == 0) ? 1 : ((cfg_keep > MAX_KEEP_DEF) ? MAX_KEEP_DEF : int'(cfg_keep));
		score = cfg_quantized ? ({8'd0, it.raw_score[7:0]} * 16'd257) : it.raw_score;
		idx = class_pos[INDEX_W-1:0];
		if (score >= cfg_threshold) begin
			n = (kept_total < cap) ? kept_total : cap;
			slot = 0;
			while (slot < n && (score < kept_scores[slot] ||
					(score == kept_scores[slot] && idx <= kept_indices[slot]))) begin
				slot++;
			end
			if (slot >= cap) begin
				kept_total = n;
			end else begin
				k = (n < cap) ? n : cap - 1;
				while (k > slot) begin
					kept_scores[k] = kept_scores[k-1];
					kept_indices[k] = kept_indices[k-1];
					k--;
				end
				kept_scores[slot] = score;
				kept_indices[slot] = idx;
				kept_total = (n < cap) ? n + 1 : cap;
			end
		end
		class_pos = (class_pos + 1) % MAX_CLASSES_DEF;
		if (it.final_score) begin
			n = (kept_total < cap) ? kept_total : cap;
			if (n == 0) begin
				r = '{confidence: '0, class_index: '0, found: 1'b0, run_end: 1'b1};
				queue_result(r);
			end
			for (k = 0; k < n; k++) begin
				r = '{confidence: kept_scores[k], class_index: kept_indices[k], found: 1'b1,
					run_end: (k == n - 1)};
				queue_result(r);
			end
			clear_ranking();
		end
	endtask

	task automatic send_item(input item_t it, input bit pinned, input result_t pin);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		rank_score(it);
		// a pinned row yields exactly one result; the typed value replaces the predicted one
		if (pinned) begin
			ranked_results.delete(ranked_results.size() - 1);
			queue_result(pin);
		end
	endtask

	task automatic pace();
		int gap;
		if (!steady) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 8);
				gap = $urandom_range(1, 12);
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// idle point for register writes: nothing pending, input stage drained
	task automatic settle();
		item_valid <= 1'b0;
		while (ranked_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KEEP_COUNT:      cfg_keep = data[KEEP_W-1:0];
			REG_SCORE_THRESHOLD: cfg_threshold = data[SCORE_W-1:0];
			REG_QUANTIZED_MODE:  cfg_quantized = data[0];
			default: ;
		endcase
	endtask

	function automatic step_t score_step(input logic [SCORE_W-1:0] raw, input int repeats,
			input logic last);
		step_t s;
		s = '{kind: ROW_ITEM, reg_idx: '0, wdata: '0, raw: raw, repeats: repeats, last: last,
			pinned: 1'b0, pin: '0};
		return s;
	endfunction

	function automatic step_t pinned_step(input logic [SCORE_W-1:0] raw, input result_t pin);
		step_t s;
		s = score_step(raw, 1, 1'b1);
		s.pinned = 1'b1;
		s.pin = pin;
		return s;
	endfunction

	function automatic step_t write_step(input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] data);
		step_t s;
		s = score_step('0, 0, 1'b0);
		s.kind = ROW_WRITE;
		s.reg_idx = idx;
		s.wdata = data;
		return s;
	endfunction

	function automatic logic [SCORE_W-1:0] pick_score(input score_style_e style,
			input logic [SCORE_W-1:0] tie_a, input logic [SCORE_W-1:0] tie_b);
		int base;
		int v;
		int top;
		case (style)
			STYLE_EDGE: begin
				top = cfg_quantized ? 255 : 65535;
				base = cfg_quantized ? (int'(cfg_threshold) + 256) / 257 : int'(cfg_threshold);
				v = base + $urandom_range(0, 4) - 2;
				if (v < 0) v = 0;
				if (v > top) v = top;
				if (cfg_quantized) v = v | ($urandom_range(0, 255) << 8);
				return v[SCORE_W-1:0];
			end
			STYLE_TIES: return $urandom_range(0, 1) ? tie_a : tie_b;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic run_phase();
		int nvec;
		int len;
		bit open_end;
		score_style_e style;
		logic [SCORE_W-1:0] tie_a;
		logic [SCORE_W-1:0] tie_b;
		int v;
		item_t it;
		settle();
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 4))
				0: v = 0;
				1: v = 1;
				2: v = 8;
				3: v = 15;
				default: v = $urandom_range(1, 8);
			endcase
			reg_write(REG_KEEP_COUNT, ($urandom() & ~32'hF) | v);
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 4))
				0: v = 0;
				1: v = 65535;
				2: v = 66;
				3: v = $urandom_range(0, 600);
				default: v = $urandom_range(0, 65535);
			endcase
			reg_write(REG_SCORE_THRESHOLD, ($urandom() & ~32'hFFFF) | v);
		end
		if ($urandom_range(0, 2) != 0) begin
			reg_write(REG_QUANTIZED_MODE, ($urandom() & ~32'h1) | $urandom_range(0, 1));
		end
		steady = ($urandom_range(0, 3) == 0);
		nvec = $urandom_range(1, 4);
		open_end = ($urandom_range(0, 4) == 0);
		for (int vec = 0; vec < nvec; vec++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
			style = score_style_e'($urandom_range(0, 2));
			tie_a = $urandom_range(0, 65535);
			tie_b = $urandom_range(0, 65535);
			for (int p = 0; p < len; p++) begin
				it.raw_score = pick_score(style, tie_a, tie_b);
				// the last vector of some phases stays open across the next register writes
				it.final_score = (p == len - 1) && !(open_end && vec == nvec - 1);
				send_item(it, 1'b0, '0);
				random_items++;
				pace();
			end
		end
	endtask

	// receiver backpressure, switching between patterns
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= ready_mode_e'($urandom_range(0, 3));
			mode_left <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			READY_ALWAYS: result_ready <= 1'b1;
			READY_COIN:   result_ready <= $urandom_range(0, 1);
			READY_MOSTLY: result_ready <= ($urandom_range(0, 7) != 0);
			READY_BURSTY: begin
				if (stall_left != 0) begin
					result_ready <= 1'b0;
					stall_left <= stall_left - 1;
				end else begin
					result_ready <= 1'b1;
					if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 40);
				end
			end
		endcase
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (ranked_results.size() == 0) begin
				log_failure($sformatf("unexpected result conf=%h idx=%0d found=%b end=%b",
					result.confidence, result.class_index, result.found, result.run_end));
			end else begin
				want = ranked_results.pop_front();
				if (result.confidence !== want.confidence || result.class_index !== want.class_index
						|| result.found !== want.found || result.run_end !== want.run_end) begin
					log_failure($sformatf(
						"conf exp %h got %h, idx exp %0d got %0d, found exp %b got %b, end exp %b got %b",
						want.confidence, result.confidence, want.class_index, result.class_index,
						want.found, result.found, want.run_end, result.run_end));
				end
			end
		end
	end

	// watchdog: any transaction restarts the count
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("top_k_select_threshold_unit_test: FAIL");
			$finish;
		end
	end

	initial begin
		step_t plan [$];
		item_t it;
		cfg_keep = KEEP_COUNT_RST;
		cfg_threshold = SCORE_THRESHOLD_RST;
		cfg_quantized = 1'b0;
		clear_ranking();

		// reset config: keep 5, threshold 66, Q0.16 scores
		plan = {plan, pinned_step(16'd0, '{16'd0, 10'd0, 1'b0, 1'b1})};      // empty run
		plan = {plan, pinned_step(16'hFFFF, '{16'hFFFF, 10'd0, 1'b1, 1'b1})};
		plan = {plan, score_step(16'd65, 1, 1'b0)};                          // just below
		plan = {plan, pinned_step(16'd66, '{16'd66, 10'd1, 1'b1, 1'b1})};   // at threshold
		plan = {plan, score_step(16'd1000, 2, 1'b0)};                        // equal scores
		plan = {plan, score_step(16'd500, 1, 1'b0)};
		plan = {plan, score_step(16'd1000, 1, 1'b1)};
		// quantized: only the low byte counts, scaled by 257
		plan = {plan, write_step(REG_QUANTIZED_MODE, 32'hFFFF_FFFF)};
		plan = {plan, pinned_step(16'hFF80, '{16'd32896, 10'd0, 1'b1, 1'b1})};
		plan = {plan, score_step(16'h00FF, 1, 1'b0)};
		plan = {plan, pinned_step(16'h0000, '{16'hFFFF, 10'd0, 1'b1, 1'b1})};
		// keep count 0 behaves as 1; a zero score passes a zero threshold
		plan = {plan, write_step(REG_KEEP_COUNT, 32'h0)};
		plan = {plan, write_step(REG_SCORE_THRESHOLD, 32'h0)};
		plan = {plan, write_step(REG_QUANTIZED_MODE, 32'h0)};
		plan = {plan, score_step(16'd0, 1, 1'b0)};
		plan = {plan, pinned_step(16'd0, '{16'd0, 10'd1, 1'b1, 1'b1})};
		// keep count 15 clamps to 8; list overflows with equal top scores
		plan = {plan, write_step(REG_KEEP_COUNT, 32'hFFFF_FFFF)};
		plan = {plan, write_step(REG_SCORE_THRESHOLD, 32'h0001_FFFF)};
		plan = {plan, write_step(REG_UNMAPPED, 32'h0000_1234)};
		plan = {plan, score_step(16'hFFFF, 9, 1'b1)};
		// keep count lowered while a vector is open
		plan = {plan, write_step(REG_KEEP_COUNT, 32'd8)};
		plan = {plan, write_step(REG_SCORE_THRESHOLD, 32'd66)};
		plan = {plan, score_step(16'd40000, 6, 1'b0)};
		plan = {plan, write_step(REG_KEEP_COUNT, 32'd2)};
		plan = {plan, score_step(16'd30000, 2, 1'b1)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				settle();
				reg_write(plan[r].reg_idx, plan[r].wdata);
			end else begin
				for (int j = 0; j < plan[r].repeats; j++) begin
					it.raw_score = plan[r].raw;
					it.final_score = plan[r].last && (j == plan[r].repeats - 1);
					send_item(it, plan[r].pinned, plan[r].pin);
					pace();
				end
			end
		end

		while (random_items < RANDOM_ITEMS) run_phase();

		settle();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("top_k_select_threshold_unit_test: PASS");
		end else begin
			$display("top_k_select_threshold_unit_test: FAIL");
		end
		$finish;
	end

endmodule
